### rtl/rk4_pkg.sv
// Shared constants, types and the control store of the RK4 integrator step.
package rk4_pkg;

  localparam int WORD_BITS       = 32;
  localparam int FRAC_BITS       = 16;
  localparam int INDEX_BITS      = 16;
  localparam int STEP_WIDTH_BITS = 31;
  localparam int CFG_DATA_BITS   = 32;
  localparam int CFG_INDEX_BITS  = 2;
  localparam int PC_BITS         = 6;
  localparam int PROD_BITS       = 2 * WORD_BITS;
  localparam int DIV_SHIFT       = WORD_BITS + 1;

  localparam logic [CFG_INDEX_BITS-1:0] REG_X_START    = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_Y_START    = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_STEP_WIDTH = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_STEP_COUNT = 2'd3;

  localparam logic [WORD_BITS-1:0]       RST_X_START    = '0;
  localparam logic [WORD_BITS-1:0]       RST_Y_START    = '0;
  localparam logic [STEP_WIDTH_BITS-1:0] RST_STEP_WIDTH = STEP_WIDTH_BITS'(6554);
  localparam logic [INDEX_BITS-1:0]      RST_STEP_COUNT = INDEX_BITS'(10);

  localparam logic [WORD_BITS-1:0] WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic [WORD_BITS-1:0] WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  // Reciprocal of three: floor(v / 3) equals (v * DIV3_MAGIC) >> 33 for any 32-bit v.
  localparam logic [WORD_BITS-1:0] DIV3_MAGIC = 32'hAAAA_AAAB;

  localparam logic [PROD_BITS:0] RND_HALF0 = (PROD_BITS+1)'(1) << (FRAC_BITS - 1);
  localparam logic [PROD_BITS:0] RND_HALF1 = (PROD_BITS+1)'(1) << FRAC_BITS;
  localparam logic [PROD_BITS:0] LIM_POS   = (PROD_BITS+1)'(WMAX);
  localparam logic [PROD_BITS:0] LIM_NEG   = (PROD_BITS+1)'(WMIN);

  typedef enum logic [2:0] {
    OP_NOP,
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_MULD,
    OP_RND,
    OP_QUO
  } op_e;

  typedef enum logic [3:0] {
    SRC_ZERO,
    SRC_X,
    SRC_Y,
    SRC_H,
    SRC_HH,
    SRC_XM,
    SRC_XE,
    SRC_K,
    SRC_S,
    SRC_U,
    SRC_T
  } src_e;

  typedef enum logic [3:0] {
    DST_NONE,
    DST_X,
    DST_Y,
    DST_XM,
    DST_XE,
    DST_K,
    DST_S,
    DST_U,
    DST_T
  } dst_e;

  typedef struct packed {
    op_e                op;
    src_e               src_a;
    src_e               src_b;
    dst_e               dst;
    logic               shift1;
    logic               skip;
    logic               cnt;
    logic               fin;
    logic [PC_BITS-1:0] jmp_to;
  } ucode_t;

  localparam logic [PC_BITS-1:0] PC_END = 6'd36;

  function automatic ucode_t mk(op_e op, src_e a, src_e b, dst_e d, logic sh);
    ucode_t w;
    w.op     = op;
    w.src_a  = a;
    w.src_b  = b;
    w.dst    = d;
    w.shift1 = sh;
    w.skip   = 1'b0;
    w.cnt    = 1'b0;
    w.fin    = 1'b0;
    w.jmp_to = '0;
    return w;
  endfunction

  // One RK4 step: half and full abscissa, four slopes, weighted sum, scale by h, divide by six.
  function automatic ucode_t ucode_rom(logic [PC_BITS-1:0] pc);
    ucode_t w;
    w = mk(OP_NOP, SRC_ZERO, SRC_ZERO, DST_NONE, 1'b0);
    case (pc)
      6'd0: begin
        w.skip   = 1'b1;
        w.jmp_to = PC_END;
      end
      6'd1:  w = mk(OP_ADD,  SRC_X,    SRC_HH,   DST_XM,   1'b0);
      6'd2:  w = mk(OP_ADD,  SRC_X,    SRC_H,    DST_XE,   1'b0);
      6'd3:  w = mk(OP_MUL,  SRC_X,    SRC_Y,    DST_NONE, 1'b0);
      6'd4:  w = mk(OP_RND,  SRC_ZERO, SRC_ZERO, DST_T,    1'b0);
      6'd5:  w = mk(OP_SUB,  SRC_X,    SRC_T,    DST_K,    1'b0);
      6'd6:  w = mk(OP_ADD,  SRC_K,    SRC_ZERO, DST_S,    1'b0);
      6'd7:  w = mk(OP_MUL,  SRC_H,    SRC_K,    DST_NONE, 1'b0);
      6'd8:  w = mk(OP_RND,  SRC_ZERO, SRC_ZERO, DST_T,    1'b1);
      6'd9:  w = mk(OP_ADD,  SRC_Y,    SRC_T,    DST_T,    1'b0);
      6'd10: w = mk(OP_MUL,  SRC_XM,   SRC_T,    DST_NONE, 1'b0);
      6'd11: w = mk(OP_RND,  SRC_ZERO, SRC_ZERO, DST_T,    1'b0);
      6'd12: w = mk(OP_SUB,  SRC_XM,   SRC_T,    DST_K,    1'b0);
      6'd13: w = mk(OP_ADD,  SRC_K,    SRC_K,    DST_U,    1'b0);
      6'd14: w = mk(OP_ADD,  SRC_S,    SRC_U,    DST_S,    1'b0);
      6'd15: w = mk(OP_MUL,  SRC_H,    SRC_K,    DST_NONE, 1'b0);
      6'd16: w = mk(OP_RND,  SRC_ZERO, SRC_ZERO, DST_T,    1'b1);
      6'd17: w = mk(OP_ADD,  SRC_Y,    SRC_T,    DST_T,    1'b0);
      6'd18: w = mk(OP_MUL,  SRC_XM,   SRC_T,    DST_NONE, 1'b0);
      6'd19: w = mk(OP_RND,  SRC_ZERO, SRC_ZERO, DST_T,    1'b0);
      6'd20: w = mk(OP_SUB,  SRC_XM,   SRC_T,    DST_K,    1'b0);
      6'd21: w = mk(OP_ADD,  SRC_K,    SRC_K,    DST_U,    1'b0);
      6'd22: w = mk(OP_ADD,  SRC_S,    SRC_U,    DST_S,    1'b0);
      6'd23: w = mk(OP_MUL,  SRC_H,    SRC_K,    DST_NONE, 1'b0);
      6'd24: w = mk(OP_RND,  SRC_ZERO, SRC_ZERO, DST_T,    1'b0);
      6'd25: w = mk(OP_ADD,  SRC_Y,    SRC_T,    DST_T,    1'b0);
      6'd26: w = mk(OP_MUL,  SRC_XE,   SRC_T,    DST_NONE, 1'b0);
      6'd27: w = mk(OP_RND,  SRC_ZERO, SRC_ZERO, DST_T,    1'b0);
      6'd28: w = mk(OP_SUB,  SRC_XE,   SRC_T,    DST_K,    1'b0);
      6'd29: w = mk(OP_ADD,  SRC_S,    SRC_K,    DST_S,    1'b0);
      6'd30: w = mk(OP_MUL,  SRC_H,    SRC_S,    DST_NONE, 1'b0);
      6'd31: w = mk(OP_RND,  SRC_ZERO, SRC_ZERO, DST_T,    1'b0);
      6'd32: w = mk(OP_MULD, SRC_T,    SRC_ZERO, DST_NONE, 1'b0);
      6'd33: w = mk(OP_QUO,  SRC_ZERO, SRC_ZERO, DST_T,    1'b0);
      6'd34: w = mk(OP_ADD,  SRC_Y,    SRC_T,    DST_Y,    1'b0);
      6'd35: begin
        w     = mk(OP_ADD, SRC_XE, SRC_ZERO, DST_X, 1'b0);
        w.cnt = 1'b1;
        w.fin = 1'b1;
      end
      default: begin
        w.fin = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

### rtl/rk4_if.sv
// Valid/ready channel interfaces for the input and result words of the RK4 step.
interface rk4_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface rk4_out_if import rk4_pkg::*; ;
  logic                         valid;
  logic                         ready;
  logic signed [WORD_BITS-1:0]  x_value;
  logic signed [WORD_BITS-1:0]  y_value;
  logic        [INDEX_BITS-1:0] step_index;
  logic                         last;
  logic                         saturated;

  modport source (
    output valid, output x_value, output y_value, output step_index,
    output last, output saturated, input ready
  );
  modport sink (
    input valid, input x_value, input y_value, input step_index,
    input last, input saturated, output ready
  );
endinterface

### rtl/rk4_ode_integrator_step.sv
// Fourth-order Runge-Kutta step engine for dy/dx = x - x*y in signed Q16.16.
//
// The input channel carries a one-bit restart word. A restart word loads the
// configured start point and returns it as step 0: it jumps from entry 0 of
// the control program to the end entry, then goes through the write-back
// state into the output register. Any other word advances one RK4 step and
// returns the new point. A step runs entries 0 to 35 of the control program
// over a 32x32 multiplier and a saturating adder before the write-back state.
// Once the configured step count is reached, advance words return the held
// point with last set, on the same short path as a restart. One word is in
// work at a time; a new word is taken only once the last one is written back.
// Results sit in an output register; a new input word is taken while the
// previous result still waits there, and the engine holds its finished point
// until that register is free when the receiver stalls.
// Configuration is a plain write port, to be used only while the block is idle.
// Reset clears the configuration to its defaults and the point to (0, 0).
module rk4_ode_integrator_step import rk4_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data_i,
  rk4_in_if.sink                    in_i,
  rk4_out_if.source                 out_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_WB   = 2'd2;

  localparam int W = WORD_BITS;

  logic [1:0]               state_q, state_d;
  logic [PC_BITS-1:0]       pc_q, pc_d;
  logic                     restart_q;
  logic                     sat_q, sat_d;
  logic [INDEX_BITS-1:0]    steps_q, steps_d;
  logic signed [W-1:0]      x_q, y_q;
  logic signed [W-1:0]      xm_q, xe_q, k_q, s_q, u_q, t_q;
  logic [PROD_BITS-1:0]     prod_q, prod_d;
  logic                     neg_q, neg_d;

  logic [W-1:0]               x_start_q, y_start_q;
  logic [STEP_WIDTH_BITS-1:0] step_width_q;
  logic [INDEX_BITS-1:0]      step_count_q;

  logic                    out_valid_q;
  logic signed [W-1:0]     out_x_q, out_y_q;
  logic [INDEX_BITS-1:0]   out_index_q;
  logic                    out_last_q, out_sat_q;

  ucode_t              uc;
  logic                in_acc;
  logic                out_free;
  logic                exhausted;
  logic                run;
  logic signed [W-1:0] h_val, hh_val;
  logic [W:0]          h_inc;
  logic signed [W-1:0] opa, opb;
  logic [W-1:0]        mag_a, mag_b;
  logic [W:0]          mag_t3;
  logic signed [W:0]   ext;
  logic [PROD_BITS:0]  rnd_sum, rnd_sh, rnd_lim;
  logic [W-1:0]        quo;
  logic signed [W-1:0] res;
  logic                res_we;
  logic                alu_sat;

  assign uc        = ucode_rom(pc_q);
  assign run       = (state_q == ST_RUN);
  assign in_acc    = in_i.valid && in_i.ready;
  assign out_free  = !out_valid_q || out_o.ready;
  assign exhausted = (steps_q >= step_count_q);
  assign h_val     = {1'b0, step_width_q};
  assign h_inc     = {1'b0, h_val} + (W+1)'(1);
  assign hh_val    = h_inc[W:1];

  always_comb begin
    case (uc.src_a)
      SRC_X:   opa = x_q;
      SRC_Y:   opa = y_q;
      SRC_H:   opa = h_val;
      SRC_HH:  opa = hh_val;
      SRC_XM:  opa = xm_q;
      SRC_XE:  opa = xe_q;
      SRC_K:   opa = k_q;
      SRC_S:   opa = s_q;
      SRC_U:   opa = u_q;
      SRC_T:   opa = t_q;
      default: opa = '0;
    endcase
  end

  always_comb begin
    case (uc.src_b)
      SRC_X:   opb = x_q;
      SRC_Y:   opb = y_q;
      SRC_H:   opb = h_val;
      SRC_HH:  opb = hh_val;
      SRC_XM:  opb = xm_q;
      SRC_XE:  opb = xe_q;
      SRC_K:   opb = k_q;
      SRC_S:   opb = s_q;
      SRC_U:   opb = u_q;
      SRC_T:   opb = t_q;
      default: opb = '0;
    endcase
  end

  assign mag_a  = opa[W-1] ? (W'(0) - opa) : opa;
  assign mag_b  = opb[W-1] ? (W'(0) - opb) : opb;
  assign mag_t3 = {1'b0, mag_a} + (W+1)'(3);

  always_comb begin
    res     = '0;
    res_we  = 1'b0;
    alu_sat = 1'b0;
    prod_d  = prod_q;
    neg_d   = neg_q;
    ext     = '0;
    rnd_sum = '0;
    rnd_sh  = '0;
    rnd_lim = LIM_POS;
    quo     = '0;
    case (uc.op)
      OP_ADD, OP_SUB: begin
        if (uc.op == OP_SUB) begin
          ext = {opa[W-1], opa} - {opb[W-1], opb};
        end else begin
          ext = {opa[W-1], opa} + {opb[W-1], opb};
        end
        res_we = 1'b1;
        if (ext[W] != ext[W-1]) begin
          alu_sat = 1'b1;
          res     = ext[W] ? WMIN : WMAX;
        end else begin
          res = ext[W-1:0];
        end
      end
      OP_MUL: begin
        prod_d = {{W{1'b0}}, mag_a} * {{W{1'b0}}, mag_b};
        neg_d  = opa[W-1] ^ opb[W-1];
      end
      OP_MULD: begin
        prod_d = {{W{1'b0}}, mag_t3[W:1]} * {{W{1'b0}}, DIV3_MAGIC};
        neg_d  = opa[W-1];
      end
      OP_RND: begin
        rnd_sum = {1'b0, prod_q} + (uc.shift1 ? RND_HALF1 : RND_HALF0);
        rnd_sh  = uc.shift1 ? (rnd_sum >> (FRAC_BITS + 1)) : (rnd_sum >> FRAC_BITS);
        rnd_lim = neg_q ? LIM_NEG : LIM_POS;
        res_we  = 1'b1;
        if (rnd_sh > rnd_lim) begin
          alu_sat = 1'b1;
          res     = neg_q ? WMIN : WMAX;
        end else begin
          res = neg_q ? (W'(0) - rnd_sh[W-1:0]) : rnd_sh[W-1:0];
        end
      end
      OP_QUO: begin
        quo    = W'(prod_q >> DIV_SHIFT);
        res_we = 1'b1;
        res    = neg_q ? (W'(0) - quo) : quo;
      end
      default: begin
        res_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    pc_d    = pc_q;
    sat_d   = sat_q;
    steps_d = steps_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_RUN;
          pc_d    = '0;
          sat_d   = 1'b0;
          if (in_i.restart) begin
            steps_d = '0;
          end
        end
      end
      ST_RUN: begin
        sat_d = sat_q | alu_sat;
        if (uc.skip && (restart_q || exhausted)) begin
          pc_d = uc.jmp_to;
        end else if (uc.fin) begin
          state_d = ST_WB;
        end else begin
          pc_d = pc_q + PC_BITS'(1);
        end
        if (uc.cnt && (steps_q != '1)) begin
          steps_d = steps_q + INDEX_BITS'(1);
        end
      end
      ST_WB: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_i.ready = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      pc_q         <= '0;
      restart_q    <= 1'b0;
      sat_q        <= 1'b0;
      steps_q      <= '0;
      x_q          <= '0;
      y_q          <= '0;
      x_start_q    <= RST_X_START;
      y_start_q    <= RST_Y_START;
      step_width_q <= RST_STEP_WIDTH;
      step_count_q <= RST_STEP_COUNT;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      sat_q   <= sat_d;
      steps_q <= steps_d;
      if (in_acc) begin
        restart_q <= in_i.restart;
        if (in_i.restart) begin
          x_q <= x_start_q;
          y_q <= y_start_q;
        end
      end
      if (run && res_we && (uc.dst == DST_X)) begin
        x_q <= res;
      end
      if (run && res_we && (uc.dst == DST_Y)) begin
        y_q <= res;
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_X_START:    x_start_q    <= cfg_data_i[W-1:0];
          REG_Y_START:    y_start_q    <= cfg_data_i[W-1:0];
          REG_STEP_WIDTH: step_width_q <= cfg_data_i[STEP_WIDTH_BITS-1:0];
          REG_STEP_COUNT: step_count_q <= cfg_data_i[INDEX_BITS-1:0];
          default: begin
          end
        endcase
      end
      if ((state_q == ST_WB) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (run) begin
      prod_q <= prod_d;
      neg_q  <= neg_d;
      if (res_we) begin
        case (uc.dst)
          DST_XM:  xm_q <= res;
          DST_XE:  xe_q <= res;
          DST_K:   k_q  <= res;
          DST_S:   s_q  <= res;
          DST_U:   u_q  <= res;
          DST_T:   t_q  <= res;
          default: begin
          end
        endcase
      end
    end
    if ((state_q == ST_WB) && out_free) begin
      out_x_q     <= x_q;
      out_y_q     <= y_q;
      out_index_q <= steps_q;
      out_last_q  <= exhausted;
      out_sat_q   <= sat_q;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.x_value    = out_x_q;
  assign out_o.y_value    = out_y_q;
  assign out_o.step_index = out_index_q;
  assign out_o.last       = out_last_q;
  assign out_o.saturated  = out_sat_q;

endmodule

### rtl/rk4_chk.sv
// Port-level assertions for the RK4 integrator step, bound to its top level.
module rk4_chk import rk4_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_i,
  input logic                    out_valid_i,
  input logic                    out_ready_i,
  input logic [WORD_BITS-1:0]    out_x_value_i,
  input logic [WORD_BITS-1:0]    out_y_value_i,
  input logic [INDEX_BITS-1:0]   out_step_index_i
);

  // A word is in work until its result is written back, so no second word is taken right after one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("input taken on the cycle after an accepted word");

  // A result never shows up on the cycle right after its word was taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_valid_i && in_ready_i))
    else $error("result appeared without any work cycles");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("result word dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      ($stable(out_x_value_i) && $stable(out_y_value_i) && $stable(out_step_index_i)))
    else $error("result word changed while stalled");

endmodule

bind rk4_ode_integrator_step rk4_chk u_rk4_chk (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_x_value_i    (out_o.x_value),
  .out_y_value_i    (out_o.y_value),
  .out_step_index_i (out_o.step_index)
);

### tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench of the RK4 integrator step with random idling and a long result stall.
module tb_top;
  import rk4_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned PHASE_ITEMS = 40;
  localparam int unsigned RAND_PHASES = 14;
  localparam int unsigned MAX_PRINTS  = 40;
  localparam longint WORD_HI = (64'sd1 <<< (WORD_BITS - 1)) - 1;
  localparam longint WORD_LO = -WORD_HI - 1;
  localparam int unsigned INDEX_MAX = (1 << INDEX_BITS) - 1;

  typedef struct {
    logic signed [WORD_BITS-1:0] x_value;
    logic signed [WORD_BITS-1:0] y_value;
    logic [INDEX_BITS-1:0]       step_index;
    logic                        last;
    logic                        saturated;
  } rk_point_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      cfg_we_i;
  logic [CFG_INDEX_BITS-1:0] cfg_index_i;
  logic [CFG_DATA_BITS-1:0]  cfg_data_i;

  rk4_in_if  in_if ();
  rk4_out_if out_if ();

  rk4_ode_integrator_step i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  logic [WORD_BITS-1:0]       cfg_x_start    = RST_X_START;
  logic [WORD_BITS-1:0]       cfg_y_start    = RST_Y_START;
  logic [STEP_WIDTH_BITS-1:0] cfg_step_width = RST_STEP_WIDTH;
  logic [INDEX_BITS-1:0]      cfg_step_count = RST_STEP_COUNT;
  longint      x_now = 0;
  longint      y_now = 0;
  int unsigned steps_done = 0;
  bit          sat_seen;

  bit          restart_q[$];
  rk_point_t   point_q[$];
  int unsigned tx_gap;
  int unsigned rx_wait;
  bit          tx_idle_on = 1'b0;
  bit          rx_idle_on = 1'b0;
  bit          hold_go = 1'b0;
  int unsigned hold_cnt = 0;
  int unsigned err_count = 0;
  int unsigned cycle_cnt = 0;
  wire         holding = hold_go && (hold_cnt < HOLD_CYCLES);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic longint clamp_word(longint v);
    if (v > WORD_HI) begin
      sat_seen = 1'b1;
      return WORD_HI;
    end
    if (v < WORD_LO) begin
      sat_seen = 1'b1;
      return WORD_LO;
    end
    return v;
  endfunction

  function automatic longint sat_add(longint a, longint b);
    return clamp_word(a + b);
  endfunction

  function automatic longint sat_sub(longint a, longint b);
    return clamp_word(a - b);
  endfunction

  function automatic longint unsigned magnitude(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint from_mag(bit neg, longint unsigned m);
    longint unsigned lim;
    lim = neg ? (64'd1 << (WORD_BITS - 1)) : (64'd1 << (WORD_BITS - 1)) - 64'd1;
    if (m > lim) begin
      sat_seen = 1'b1;
      m = lim;
    end
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint fixed_mul(longint a, longint b, int unsigned sh);
    bit              neg;
    longint unsigned prod;
    neg  = (a < 0) != (b < 0);
    prod = magnitude(a) * magnitude(b);
    return from_mag(neg, (prod + (64'd1 << (sh - 1))) >> sh);
  endfunction

  function automatic longint slope_at(longint x, longint y);
    return sat_sub(x, fixed_mul(x, y, FRAC_BITS));
  endfunction

  function automatic rk_point_t next_point(bit restart);
    longint    h, hh, xm, k1, k2, k3, k4, total, t, d;
    rk_point_t p;
    sat_seen = 1'b0;
    if (restart) begin
      x_now      = $signed(cfg_x_start);
      y_now      = $signed(cfg_y_start);
      steps_done = 0;
    end else if (steps_done < cfg_step_count) begin
      h     = clamp_word(longint'(cfg_step_width));
      hh    = (h + 1) >>> 1;
      xm    = sat_add(x_now, hh);
      k1    = slope_at(x_now, y_now);
      k2    = slope_at(xm, sat_add(y_now, fixed_mul(h, k1, FRAC_BITS + 1)));
      k3    = slope_at(xm, sat_add(y_now, fixed_mul(h, k2, FRAC_BITS + 1)));
      k4    = slope_at(sat_add(x_now, h), sat_add(y_now, fixed_mul(h, k3, FRAC_BITS)));
      total = sat_add(sat_add(sat_add(k1, sat_add(k2, k2)), sat_add(k3, k3)), k4);
      t     = fixed_mul(h, total, FRAC_BITS);
      d     = from_mag(t < 0, (magnitude(t) + 3) / 6);
      y_now = sat_add(y_now, d);
      x_now = sat_add(x_now, h);
      if (steps_done < INDEX_MAX) steps_done++;
    end
    p.x_value    = x_now[WORD_BITS-1:0];
    p.y_value    = y_now[WORD_BITS-1:0];
    p.step_index = steps_done[INDEX_BITS-1:0];
    p.last       = steps_done >= cfg_step_count;
    p.saturated  = sat_seen;
    return p;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    if (err_count < MAX_PRINTS) begin
      $display("%0t tb_top: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    end
    err_count++;
  endtask

  task automatic check_point();
    rk_point_t want;
    if (point_q.size() == 0) begin
      report_mismatch("unexpected word", 0, 0);
      return;
    end
    want = point_q.pop_front();
    if (out_if.x_value !== want.x_value) begin
      report_mismatch("x_value", longint'(out_if.x_value), longint'(want.x_value));
    end
    if (out_if.y_value !== want.y_value) begin
      report_mismatch("y_value", longint'(out_if.y_value), longint'(want.y_value));
    end
    if (out_if.step_index !== want.step_index) begin
      report_mismatch("step_index", longint'(out_if.step_index), longint'(want.step_index));
    end
    if (out_if.last !== want.last) begin
      report_mismatch("last", longint'(out_if.last), longint'(want.last));
    end
    if (out_if.saturated !== want.saturated) begin
      report_mismatch("saturated", longint'(out_if.saturated), longint'(want.saturated));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : word_driver
    if (!rst_ni) begin
      in_if.valid   <= 1'b0;
      in_if.restart <= 1'b0;
      tx_gap        <= 0;
    end else begin
      if (in_if.valid && in_if.ready) point_q.push_back(next_point(in_if.restart));
      if (!in_if.valid || in_if.ready) begin
        if (tx_gap != 0) begin
          in_if.valid <= 1'b0;
          tx_gap      <= tx_gap - 1;
        end else if (restart_q.size() != 0) begin
          in_if.valid   <= 1'b1;
          in_if.restart <= restart_q.pop_front();
          tx_gap        <= tx_idle_on ? $urandom_range(0, 9) : 0;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : result_monitor
    int unsigned wait_n;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      rx_wait      <= 0;
    end else begin
      wait_n = (rx_wait != 0) ? rx_wait - 1 : 0;
      if (out_if.valid && out_if.ready) begin
        check_point();
        wait_n = rx_idle_on ? $urandom_range(0, 9) : 0;
      end
      rx_wait      <= wait_n;
      out_if.ready <= (wait_n == 0) && !holding;
    end
  end

  always @(posedge clk_i) begin
    if (!hold_go) begin
      hold_cnt <= 0;
    end else if (hold_cnt < HOLD_CYCLES) begin
      hold_cnt <= hold_cnt + 1;
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  task automatic write_config(logic [31:0] xs, logic [31:0] ys, logic [31:0] hw,
                              logic [31:0] nw);
    logic [CFG_DATA_BITS-1:0]  data [4];
    logic [CFG_INDEX_BITS-1:0] reg_ids [4];
    data[0]    = xs;
    data[1]    = ys;
    data[2]    = hw;
    data[3]    = nw;
    reg_ids[0] = REG_X_START;
    reg_ids[1] = REG_Y_START;
    reg_ids[2] = REG_STEP_WIDTH;
    reg_ids[3] = REG_STEP_COUNT;
    cfg_x_start    = xs;
    cfg_y_start    = ys;
    cfg_step_width = hw[STEP_WIDTH_BITS-1:0];
    cfg_step_count = nw[INDEX_BITS-1:0];
    for (int i = 0; i < 4; i++) begin
      @(posedge clk_i);
      cfg_we_i    <= 1'b1;
      cfg_index_i <= reg_ids[i];
      cfg_data_i  <= data[i];
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic queue_run(int unsigned advances);
    restart_q.push_back(1'b1);
    repeat (advances) restart_q.push_back(1'b0);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    while (restart_q.size() != 0 || in_if.valid || point_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  initial begin
    int unsigned sent;
    int unsigned run;
    int unsigned run_cap;
    logic [31:0] xs, ys, hw, nw;
    cfg_we_i      = 1'b0;
    cfg_index_i   = REG_X_START;
    cfg_data_i    = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Defaults after reset: advances from (0, 0), then a run past the step count.
    repeat (3) restart_q.push_back(1'b0);
    queue_run(12);
    wait_idle();

    write_config(32'h0001_0000, 32'h0000_8000, 32'd6554, 32'd0);
    queue_run(1);
    wait_idle();

    write_config(WMAX, WMIN, 32'h7FFF_FFFF, 32'h0000_FFFF);
    queue_run(3);
    wait_idle();

    write_config(WMIN, WMAX, 32'h8000_0001, 32'hFFFF_0003);
    queue_run(2);
    wait_idle();

    write_config(32'hFFFE_0000, 32'h0002_0000, 32'd0, 32'd2);
    queue_run(3);
    wait_idle();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      xs = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h10_0000) - 32'h8_0000;
      ys = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h10_0000) - 32'h8_0000;
      hw = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(1, 32'h2_0000);
      hw[31] = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 5))
        0: nw = 32'h0000_FFFF;
        1: nw = $urandom_range(0, 32'hFFFF);
        default: nw = $urandom_range(0, 40);
      endcase
      nw[31:16] = 16'($urandom);
      write_config(xs, ys, hw, nw);
      hold_go    = (ph == 3);
      tx_idle_on = (ph != 3) && ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      run_cap    = (nw[15:0] < 30) ? nw[15:0] + 3 : 33;
      sent       = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 7) == 0) begin
          restart_q.push_back(1'($urandom_range(0, 1)));
          sent++;
        end else begin
          run = $urandom_range(0, run_cap);
          queue_run(run);
          sent += run + 1;
        end
      end
      wait_idle();
      hold_go = 1'b0;
    end

    repeat (40) @(posedge clk_i);
    if (err_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/rk4_pkg.sv
rtl/rk4_if.sv
rtl/rk4_ode_integrator_step.sv
rtl/rk4_chk.sv
tb/tb_top.sv
